[src/swm_pkg.sv]
// ----------------------------------------------------------------------------
// swm_pkg: shared types and constants of the star wildcard matcher
// character codes, command codes and the structs passed along the cell chain
// ----------------------------------------------------------------------------
package swm_pkg;

  localparam logic [7:0] STAR_CH = 8'h2A;
  localparam logic [7:0] DOT_CH  = 8'h2E;

  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_NAME   = 2'd2,
    CMD_EMPTY  = 2'd3
  } swm_cmd_e;

  // broadcast control, same for every cell
  typedef struct packed {
    logic       clear;       // drop the whole pattern
    logic       append;      // store ch in the first empty cell
    logic       step;        // advance the reach bits by one name character
    logic       from_start;  // first character of a name: use start closure
    logic [7:0] ch;
  } swm_ctrl_t;

  // handed from cell i to cell i+1
  typedef struct packed {
    logic valid;      // left cell holds a pattern character
    logic fwd_match;  // left cell literal matched, reaches this position
    logic fwd_close;  // left star reached, closure carries into this position
    logic start;      // start closure reaches this position
  } swm_link_t;

endpackage

[src/swm_cell.sv]
// ----------------------------------------------------------------------------
// swm_cell: one pattern position of the star wildcard matcher
// holds one pattern character, its valid bit and its reach bit
// ----------------------------------------------------------------------------
module swm_cell import swm_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  swm_ctrl_t ctrl_i,
  input  swm_link_t link_i,
  output swm_link_t link_o,
  output logic      hit_o,
  output logic      start_hit_o
);

  logic [7:0] pat_q;
  logic       valid_q;
  logic       reach_q;
  logic       reach_d;
  logic       is_star;
  logic       lit_hit;
  logic       reach_eff;
  logic       is_end;
  logic       load;

  assign is_star   = valid_q & (pat_q == STAR_CH);
  assign lit_hit   = valid_q & (pat_q != STAR_CH) & (pat_q == ctrl_i.ch);
  assign reach_eff = ctrl_i.from_start ? link_i.start : reach_q;

  // a star holds its own reach, literals and closure come in from the left
  assign reach_d = (reach_eff & is_star) | link_i.fwd_match | link_i.fwd_close;

  assign link_o.valid     = valid_q;
  assign link_o.fwd_match = reach_eff & lit_hit;
  assign link_o.fwd_close = reach_d & is_star;
  assign link_o.start     = link_i.start & is_star;

  // this position is the pattern length when left is filled and this one is not
  assign is_end      = link_i.valid & ~valid_q;
  assign hit_o       = reach_d & is_end;
  assign start_hit_o = link_i.start & is_end;

  assign load = ctrl_i.append & link_i.valid & ~valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      reach_q <= 1'b0;
    end else begin
      if (ctrl_i.clear) begin
        valid_q <= 1'b0;
      end else if (load) begin
        valid_q <= 1'b1;
      end
      if (ctrl_i.step) begin
        reach_q <= reach_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      pat_q <= ctrl_i.ch;
    end
  end

endmodule

[src/star_wildcard_matcher_top.sv]
// ----------------------------------------------------------------------------
// star_wildcard_matcher_top: glob matcher with '*' as the only wildcard
// pattern held in a chain of cells, name characters streamed, while in_ready_o is high, one per cycle
// ----------------------------------------------------------------------------
//
//  channel  | direction | handshake               | payload
//  ---------+-----------+-------------------------+--------------------------------
//  input    | in        | in_valid_i / in_ready_o | cmd_i, ch_i, last_i
//  result   | out       | out_valid_o/ out_ready_i| matched_o, pattern_overflow_o
//
//  - one input transfer per cycle is sustained while in_ready_o is high
//  - the longest path is the star closure that ripples through all PAT_MAX
//    cells combinationally, like a carry chain
//  - a result reaches the output register the cycle after its transfer when
//    that register is free, otherwise it waits in the skid entry
//  - a two-entry output buffer (register plus skid) lets input continue while
//    a result waits; input stalls only when both entries are full
//  - after reset the pattern is empty and the next name starts fresh
//
module star_wildcard_matcher_top import swm_pkg::*; #(
  parameter int PAT_MAX = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] cmd_i,
  input  logic [7:0] ch_i,
  input  logic       last_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       matched_o,
  output logic       pattern_overflow_o
);

  // cell chain wiring, link[0] is the virtual position before the first cell
  swm_link_t           link [PAT_MAX+1];
  logic [PAT_MAX:0]    hit_vec;
  logic [PAT_MAX:0]    start_hit_vec;
  swm_ctrl_t           ctrl;

  // name and pattern status
  logic at_start_q, at_start_d;
  logic hidden_q, hidden_d;
  logic ovf_q, ovf_d;

  // output buffer
  logic out_v_q, skid_v_q;
  logic out_m_q, out_o_q, skid_m_q, skid_o_q;

  logic     in_fire;
  swm_cmd_e cmd;
  logic     res_v;
  logic     res_m;
  logic     hidden_eff;

  assign in_ready_o = ~skid_v_q;
  assign in_fire    = in_valid_i & in_ready_o;
  assign cmd        = swm_cmd_e'(cmd_i);

  assign link[0].valid     = 1'b1;
  assign link[0].fwd_match = 1'b0;
  assign link[0].fwd_close = 1'b0;
  assign link[0].start     = 1'b1;

  genvar gi;
  generate
    for (gi = 0; gi < PAT_MAX; gi++) begin : g_cell
      swm_cell u_cell (
        .clk_i       (clk_i),
        .rst_ni      (rst_ni),
        .ctrl_i      (ctrl),
        .link_i      (link[gi]),
        .link_o      (link[gi+1]),
        .hit_o       (hit_vec[gi]),
        .start_hit_o (start_hit_vec[gi])
      );
    end
  endgenerate

  // position PAT_MAX: pattern completely full
  assign hit_vec[PAT_MAX] = (link[PAT_MAX].fwd_match | link[PAT_MAX].fwd_close)
                            & link[PAT_MAX].valid;
  assign start_hit_vec[PAT_MAX] = link[PAT_MAX].start & link[PAT_MAX].valid;

  // first name character decides whether the name is hidden
  assign hidden_eff = at_start_q ? (ch_i == DOT_CH) : hidden_q;

  always_comb begin
    ctrl.clear      = 1'b0;
    ctrl.append     = 1'b0;
    ctrl.step       = 1'b0;
    ctrl.from_start = at_start_q;
    ctrl.ch         = ch_i;
    at_start_d      = at_start_q;
    hidden_d        = hidden_q;
    ovf_d           = ovf_q;
    res_v           = 1'b0;
    res_m           = 1'b0;
    if (in_fire) begin
      case (cmd)
        CMD_CLEAR: begin
          ctrl.clear = 1'b1;
          ovf_d      = 1'b0;
          at_start_d = 1'b1;
          hidden_d   = 1'b0;
        end
        CMD_APPEND: begin
          ctrl.append = 1'b1;
          // append with every cell filled drops the character
          if (link[PAT_MAX].valid) begin
            ovf_d = 1'b1;
          end
          at_start_d = 1'b1;
          hidden_d   = 1'b0;
        end
        CMD_NAME: begin
          ctrl.step = 1'b1;
          if (last_i) begin
            res_v      = 1'b1;
            res_m      = (|hit_vec) & ~hidden_eff & ~ovf_q;
            at_start_d = 1'b1;
            hidden_d   = 1'b0;
          end else begin
            at_start_d = 1'b0;
            hidden_d   = hidden_eff;
          end
        end
        CMD_EMPTY: begin
          // empty name: matched only by an empty or all-star pattern
          res_v      = 1'b1;
          res_m      = (|start_hit_vec) & ~ovf_q;
          at_start_d = 1'b1;
          hidden_d   = 1'b0;
        end
        default: begin
          at_start_d = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      at_start_q <= 1'b1;
      hidden_q   <= 1'b0;
      ovf_q      <= 1'b0;
    end else begin
      at_start_q <= at_start_d;
      hidden_q   <= hidden_d;
      ovf_q      <= ovf_d;
    end
  end

  // output register with skid entry behind it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (skid_v_q) begin
      if (out_ready_i) begin
        skid_v_q <= 1'b0;
      end
    end else if (!out_v_q || out_ready_i) begin
      out_v_q <= res_v;
    end else if (res_v) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_v_q) begin
      if (out_ready_i) begin
        out_m_q <= skid_m_q;
        out_o_q <= skid_o_q;
      end
    end else if (!out_v_q || out_ready_i) begin
      out_m_q <= res_m;
      out_o_q <= ovf_q;
    end else begin
      skid_m_q <= res_m;
      skid_o_q <= ovf_q;
    end
  end

  assign out_valid_o        = out_v_q;
  assign matched_o          = out_m_q;
  assign pattern_overflow_o = out_o_q;

endmodule
